// ----- rtl/core/vtq_pkg.sv -----
// Shared types, constants and helpers for the virtual trackball quaternion unit.
package vtq_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int QUAT_FRAC_BITS  = 14;
  localparam int UFRAC           = 24;
  localparam int U_SHIFT         = UFRAC - COORD_FRAC_BITS;
  localparam int AXIS_EPS        = 1678;
  localparam int ONE_U           = 1 << UFRAC;
  localparam int ONE2            = 1 << (2 * COORD_FRAC_BITS);
  localparam int QUAT_ONE        = 1 << QUAT_FRAC_BITS;

  // iterative unit: one root bit or one quotient bit per cycle
  localparam int SQ_STEPS = 28;
  localparam int DV_STEPS = 25;

  typedef logic signed [27:0] crd_t;
  typedef logic signed [59:0] acc_t;
  typedef logic        [55:0] wide_t;
  typedef logic        [27:0] root_t;
  typedef logic signed [15:0] qv_t;
  typedef logic        [5:0]  step_t;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_RESET  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_MAC  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } alu_op_e;

  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'b0001,
    SEQ_ISSUE = 4'b0010,
    SEQ_WAIT  = 4'b0100,
    SEQ_DONE  = 4'b1000
  } seq_state_e;

  // sequencer steps
  localparam step_t STP_P_XX = 6'd0;
  localparam step_t STP_P_YY = 6'd1;
  localparam step_t STP_P_SQ = 6'd2;
  localparam step_t STP_P_DX = 6'd3;
  localparam step_t STP_P_DY = 6'd4;
  localparam step_t STP_C_0  = 6'd5;
  localparam step_t STP_C_1  = 6'd6;
  localparam step_t STP_C_2  = 6'd7;
  localparam step_t STP_C_3  = 6'd8;
  localparam step_t STP_C_4  = 6'd9;
  localparam step_t STP_C_5  = 6'd10;
  localparam step_t STP_D_0  = 6'd11;
  localparam step_t STP_D_1  = 6'd12;
  localparam step_t STP_D_2  = 6'd13;
  localparam step_t STP_L_0  = 6'd14;
  localparam step_t STP_L_1  = 6'd15;
  localparam step_t STP_L_2  = 6'd16;
  localparam step_t STP_L_SQ = 6'd17;
  localparam step_t STP_H_S  = 6'd18;
  localparam step_t STP_H_C  = 6'd19;
  localparam step_t STP_V_M0 = 6'd20;
  localparam step_t STP_V_D0 = 6'd21;
  localparam step_t STP_V_M1 = 6'd22;
  localparam step_t STP_V_D1 = 6'd23;
  localparam step_t STP_V_M2 = 6'd24;
  localparam step_t STP_V_D2 = 6'd25;
  localparam step_t STP_Q_0  = 6'd26;
  localparam step_t STP_Q_15 = 6'd41;

  // Hamilton product signs, bit [row*4+col] set where the term subtracts
  localparam logic [15:0] HAM_SUB = 16'h428E;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic        clr;
    logic        sub;
    crd_t        mul_a;
    crd_t        mul_b;
    wide_t       wide;
    root_t       dvsr;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    acc_t  acc;
    root_t res;
  } alu_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  req_type;
    qv_t         x;
    qv_t         y;
  } seq_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic drag;
    qv_t  qw;
    qv_t  qx;
    qv_t  qy;
    qv_t  qz;
  } seq_sts_t;

  function automatic qv_t to_quat(acc_t a);
    acc_t r;
    qv_t  q;
    r = (a + (acc_t'(1) <<< (UFRAC - 1))) >>> UFRAC;
    if (r > acc_t'(QUAT_ONE)) begin
      q = qv_t'(QUAT_ONE);
    end else if (r < -acc_t'(QUAT_ONE)) begin
      q = -qv_t'(QUAT_ONE);
    end else begin
      q = qv_t'(r);
    end
    return q;
  endfunction

  function automatic crd_t clamp_dot(acc_t a);
    acc_t r;
    crd_t d;
    r = a >>> UFRAC;
    if (r > acc_t'(ONE_U)) begin
      d = crd_t'(ONE_U);
    end else if (r < -acc_t'(ONE_U)) begin
      d = -crd_t'(ONE_U);
    end else begin
      d = crd_t'(r);
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/vtq_if.sv -----
// Request and response channel interfaces of the trackball unit.
interface vtq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  modport source (output valid, req_type, cursor_x, cursor_y, input ready);
  modport sink (input valid, req_type, cursor_x, cursor_y, output ready);
endinterface

interface vtq_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic              rotating_now;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, rotating_now, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, rotating_now, output ready);
endinterface

// ----- rtl/core/virtual_trackball_quaternion_unit.sv -----
// Top level of the virtual trackball quaternion unit: request intake and result register.
// Start, stop, reset and idle-update requests go straight to the done state; the result is
// registered once the output register is free. A drag update runs on one shared multiply /
// root / divide unit that resolves one bit per cycle; its steps depend on points off the
// unit disc and on an axis too short to rotate. One request at a time; the next is taken
// while a finished result waits in the output register. Reset: no drag, previous point zero,
// orientation the identity quaternion.
module virtual_trackball_quaternion_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  vtq_req_if.sink        req_i,
  vtq_rsp_if.source      rsp_o
);

  vtq_pkg::seq_cmd_t seq_cmd;
  vtq_pkg::seq_sts_t seq_sts;
  vtq_pkg::alu_req_t alu_req;
  vtq_pkg::alu_rsp_t alu_rsp;
  logic              out_free;
  logic              out_valid_q;
  vtq_pkg::qv_t      qw_q, qx_q, qy_q, qz_q;
  logic              rot_q;

  assign req_i.ready      = seq_sts.idle;
  assign seq_cmd.valid    = req_i.valid && seq_sts.idle;
  assign seq_cmd.req_type = req_i.req_type;
  assign seq_cmd.x        = req_i.cursor_x;
  assign seq_cmd.y        = req_i.cursor_y;
  assign out_free         = !out_valid_q || rsp_o.ready;

  vtq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (seq_cmd),
    .out_free_i (out_free),
    .sts_o      (seq_sts),
    .alu_req_o  (alu_req),
    .alu_rsp_i  (alu_rsp)
  );

  vtq_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_sts.done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_sts.done) begin
      qw_q  <= seq_sts.qw;
      qx_q  <= seq_sts.qx;
      qy_q  <= seq_sts.qy;
      qz_q  <= seq_sts.qz;
      rot_q <= seq_sts.drag;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.quat_w       = qw_q;
  assign rsp_o.quat_x       = qx_q;
  assign rsp_o.quat_y       = qy_q;
  assign rsp_o.quat_z       = qz_q;
  assign rsp_o.rotating_now = rot_q;

`ifndef SYNTHESIS
  a_done_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_sts.done |-> (!out_valid_q || rsp_o.ready))
    else $error("result produced while output register still occupied");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request taken before the first completed");

  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.quat_w <= 16'sd16384 && rsp_o.quat_w >= -16'sd16384 &&
                     rsp_o.quat_x <= 16'sd16384 && rsp_o.quat_x >= -16'sd16384 &&
                     rsp_o.quat_y <= 16'sd16384 && rsp_o.quat_y >= -16'sd16384 &&
                     rsp_o.quat_z <= 16'sd16384 && rsp_o.quat_z >= -16'sd16384))
    else $error("quaternion component outside saturation range");
`endif

endmodule

// ----- rtl/core/vtq_alu.sv -----
// Shared arithmetic unit: multiply-accumulate, bit-serial square root and division.
module vtq_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtq_pkg::alu_req_t  req_i,
  output vtq_pkg::alu_rsp_t  rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic                 sqrt_q;
  logic [4:0]           cnt_q;
  vtq_pkg::acc_t        acc_q;
  vtq_pkg::wide_t       v_q;
  logic [56:0]          r_q;
  logic [56:0]          b_q;
  vtq_pkg::root_t       quo_q;

  logic signed [55:0]   prod_w;
  logic [56:0]          rhs_w;
  logic                 ge_w;
  vtq_pkg::wide_t       diff_w;

  assign prod_w = req_i.mul_a * req_i.mul_b;
  assign rhs_w  = sqrt_q ? (r_q + b_q) : r_q;
  assign ge_w   = {1'b0, v_q} >= rhs_w;
  assign diff_w = v_q - rhs_w[55:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        case (req_i.op)
          vtq_pkg::OP_MAC: begin
            done_q <= 1'b1;
          end
          vtq_pkg::OP_SQRT: begin
            busy_q <= 1'b1;
            sqrt_q <= 1'b1;
            cnt_q  <= 5'(vtq_pkg::SQ_STEPS - 1);
          end
          vtq_pkg::OP_DIV: begin
            busy_q <= 1'b1;
            sqrt_q <= 1'b0;
            cnt_q  <= 5'(vtq_pkg::DV_STEPS - 1);
          end
          default: begin
            done_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      case (req_i.op)
        vtq_pkg::OP_MAC: begin
          if (req_i.clr) begin
            acc_q <= req_i.sub ? -vtq_pkg::acc_t'(prod_w) : vtq_pkg::acc_t'(prod_w);
          end else begin
            acc_q <= req_i.sub ? acc_q - vtq_pkg::acc_t'(prod_w)
                               : acc_q + vtq_pkg::acc_t'(prod_w);
          end
        end
        vtq_pkg::OP_SQRT: begin
          v_q <= req_i.wide;
          r_q <= '0;
          b_q <= 57'(1) << (2 * (vtq_pkg::SQ_STEPS - 1));
        end
        vtq_pkg::OP_DIV: begin
          v_q   <= req_i.wide;
          r_q   <= 57'(req_i.dvsr) << (vtq_pkg::DV_STEPS - 1);
          quo_q <= '0;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (ge_w) begin
          v_q <= diff_w;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end else begin
        if (ge_w) begin
          v_q   <= diff_w;
          quo_q <= {quo_q[26:0], 1'b1};
        end else begin
          quo_q <= {quo_q[26:0], 1'b0};
        end
        r_q <= r_q >> 1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.res  = sqrt_q ? r_q[27:0] : quo_q;

endmodule

// ----- rtl/core/vtq_seq.sv -----
// Event sequencer: trackball state, operand selection and write-back around the shared unit.
module vtq_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtq_pkg::seq_cmd_t  cmd_i,
  input  logic               out_free_i,
  output vtq_pkg::seq_sts_t  sts_o,
  output vtq_pkg::alu_req_t  alu_req_o,
  input  vtq_pkg::alu_rsp_t  alu_rsp_i
);

  vtq_pkg::seq_state_e state_q;
  vtq_pkg::step_t      step_q;
  vtq_pkg::step_t      step_nx;
  logic                pt_q;
  logic                drag_q;
  vtq_pkg::qv_t        px_q, py_q, cx_q, cy_q;
  vtq_pkg::qv_t        q_q [4];
  vtq_pkg::qv_t        nq_q [4];
  vtq_pkg::crd_t       d_q [4];
  vtq_pkg::crd_t       fx_q, fy_q, fz_q, nx_q, ny_q, nz_q;
  vtq_pkg::crd_t       ax_q, ay_q, az_q, dot_q;
  logic [31:0]         s_q;
  vtq_pkg::root_t      len_q, sn_q;

  vtq_pkg::qv_t        cur_x, cur_y;
  logic [15:0]         mag_x, mag_y;
  logic                outside;
  logic [24:0]         rad_in;
  vtq_pkg::acc_t       acc_mag;
  logic [3:0]          qj;
  logic                wb;
  logic                fin;
  logic                pt_adv;
  vtq_pkg::crd_t       res_c;
  vtq_pkg::crd_t       quo_s;

  assign cur_x   = pt_q ? cx_q : px_q;
  assign cur_y   = pt_q ? cy_q : py_q;
  assign mag_x   = cur_x[15] ? 16'(-cur_x) : 16'(cur_x);
  assign mag_y   = cur_y[15] ? 16'(-cur_y) : 16'(cur_y);
  assign outside = s_q > 32'(vtq_pkg::ONE2);
  assign rad_in  = 25'(vtq_pkg::ONE2) - s_q[24:0];
  assign acc_mag = alu_rsp_i.acc[59] ? -alu_rsp_i.acc : alu_rsp_i.acc;
  assign qj      = 4'(step_q - vtq_pkg::STP_Q_0);
  assign wb      = (state_q == vtq_pkg::SEQ_WAIT) && alu_rsp_i.done;
  assign res_c   = vtq_pkg::crd_t'(alu_rsp_i.res);
  assign quo_s   = alu_rsp_i.acc[59] ? -res_c : res_c;

  always_comb begin
    alu_req_o       = '0;
    alu_req_o.start = (state_q == vtq_pkg::SEQ_ISSUE);
    alu_req_o.op    = vtq_pkg::OP_MAC;
    alu_req_o.dvsr  = len_q;
    case (step_q)
      vtq_pkg::STP_P_XX: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = vtq_pkg::crd_t'(cur_x);
        alu_req_o.mul_b = vtq_pkg::crd_t'(cur_x);
      end
      vtq_pkg::STP_P_YY: begin
        alu_req_o.mul_a = vtq_pkg::crd_t'(cur_y);
        alu_req_o.mul_b = vtq_pkg::crd_t'(cur_y);
      end
      vtq_pkg::STP_P_SQ: begin
        alu_req_o.op   = vtq_pkg::OP_SQRT;
        alu_req_o.wide = outside ? vtq_pkg::wide_t'(s_q) << (2 * vtq_pkg::U_SHIFT)
                                 : vtq_pkg::wide_t'(rad_in) << (2 * vtq_pkg::U_SHIFT);
      end
      vtq_pkg::STP_P_DX: begin
        alu_req_o.op   = vtq_pkg::OP_DIV;
        alu_req_o.wide = vtq_pkg::wide_t'(mag_x)
                         << (2 * vtq_pkg::UFRAC - vtq_pkg::COORD_FRAC_BITS);
      end
      vtq_pkg::STP_P_DY: begin
        alu_req_o.op   = vtq_pkg::OP_DIV;
        alu_req_o.wide = vtq_pkg::wide_t'(mag_y)
                         << (2 * vtq_pkg::UFRAC - vtq_pkg::COORD_FRAC_BITS);
      end
      vtq_pkg::STP_C_0: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = fy_q;
        alu_req_o.mul_b = nz_q;
      end
      vtq_pkg::STP_C_1: begin
        alu_req_o.sub   = 1'b1;
        alu_req_o.mul_a = fz_q;
        alu_req_o.mul_b = ny_q;
      end
      vtq_pkg::STP_C_2: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = fz_q;
        alu_req_o.mul_b = nx_q;
      end
      vtq_pkg::STP_C_3: begin
        alu_req_o.sub   = 1'b1;
        alu_req_o.mul_a = fx_q;
        alu_req_o.mul_b = nz_q;
      end
      vtq_pkg::STP_C_4: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = fx_q;
        alu_req_o.mul_b = ny_q;
      end
      vtq_pkg::STP_C_5: begin
        alu_req_o.sub   = 1'b1;
        alu_req_o.mul_a = fy_q;
        alu_req_o.mul_b = nx_q;
      end
      vtq_pkg::STP_D_0: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = fx_q;
        alu_req_o.mul_b = nx_q;
      end
      vtq_pkg::STP_D_1: begin
        alu_req_o.mul_a = fy_q;
        alu_req_o.mul_b = ny_q;
      end
      vtq_pkg::STP_D_2: begin
        alu_req_o.mul_a = fz_q;
        alu_req_o.mul_b = nz_q;
      end
      vtq_pkg::STP_L_0: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = ax_q;
        alu_req_o.mul_b = ax_q;
      end
      vtq_pkg::STP_L_1: begin
        alu_req_o.mul_a = ay_q;
        alu_req_o.mul_b = ay_q;
      end
      vtq_pkg::STP_L_2: begin
        alu_req_o.mul_a = az_q;
        alu_req_o.mul_b = az_q;
      end
      vtq_pkg::STP_L_SQ: begin
        alu_req_o.op   = vtq_pkg::OP_SQRT;
        alu_req_o.wide = vtq_pkg::wide_t'(alu_rsp_i.acc);
      end
      vtq_pkg::STP_H_S: begin
        alu_req_o.op   = vtq_pkg::OP_SQRT;
        alu_req_o.wide = vtq_pkg::wide_t'(vtq_pkg::crd_t'(vtq_pkg::ONE_U) - dot_q)
                         << (vtq_pkg::UFRAC - 1);
      end
      vtq_pkg::STP_H_C: begin
        alu_req_o.op   = vtq_pkg::OP_SQRT;
        alu_req_o.wide = vtq_pkg::wide_t'(vtq_pkg::crd_t'(vtq_pkg::ONE_U) + dot_q)
                         << (vtq_pkg::UFRAC - 1);
      end
      vtq_pkg::STP_V_M0: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = vtq_pkg::crd_t'(sn_q);
        alu_req_o.mul_b = ax_q;
      end
      vtq_pkg::STP_V_M1: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = vtq_pkg::crd_t'(sn_q);
        alu_req_o.mul_b = ay_q;
      end
      vtq_pkg::STP_V_M2: begin
        alu_req_o.clr   = 1'b1;
        alu_req_o.mul_a = vtq_pkg::crd_t'(sn_q);
        alu_req_o.mul_b = az_q;
      end
      vtq_pkg::STP_V_D0, vtq_pkg::STP_V_D1, vtq_pkg::STP_V_D2: begin
        alu_req_o.op   = vtq_pkg::OP_DIV;
        alu_req_o.wide = vtq_pkg::wide_t'(acc_mag);
      end
      default: begin
        // quaternion product terms
        alu_req_o.clr   = (qj[1:0] == 2'd0);
        alu_req_o.sub   = vtq_pkg::HAM_SUB[qj];
        alu_req_o.mul_a = d_q[qj[1:0]];
        alu_req_o.mul_b = vtq_pkg::crd_t'(q_q[qj[3:2] ^ qj[1:0]]);
      end
    endcase
  end

  always_comb begin
    step_nx = step_q + 6'd1;
    fin     = 1'b0;
    pt_adv  = 1'b0;
    case (step_q)
      vtq_pkg::STP_P_SQ: begin
        if (!outside) begin
          pt_adv  = 1'b1;
          step_nx = pt_q ? vtq_pkg::STP_C_0 : vtq_pkg::STP_P_XX;
        end
      end
      vtq_pkg::STP_P_DY: begin
        pt_adv  = 1'b1;
        step_nx = pt_q ? vtq_pkg::STP_C_0 : vtq_pkg::STP_P_XX;
      end
      vtq_pkg::STP_L_SQ: begin
        fin = alu_rsp_i.res <= vtq_pkg::root_t'(vtq_pkg::AXIS_EPS);
      end
      vtq_pkg::STP_Q_15: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vtq_pkg::SEQ_IDLE;
      step_q  <= vtq_pkg::STP_P_XX;
      pt_q    <= 1'b0;
      drag_q  <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
      q_q[0]  <= vtq_pkg::qv_t'(vtq_pkg::QUAT_ONE);
      q_q[1]  <= '0;
      q_q[2]  <= '0;
      q_q[3]  <= '0;
    end else begin
      case (state_q)
        vtq_pkg::SEQ_IDLE: begin
          if (cmd_i.valid) begin
            state_q <= vtq_pkg::SEQ_DONE;
            case (vtq_pkg::req_e'(cmd_i.req_type))
              vtq_pkg::REQ_START: begin
                drag_q <= 1'b1;
                px_q   <= cmd_i.x;
                py_q   <= cmd_i.y;
              end
              vtq_pkg::REQ_UPDATE: begin
                if (drag_q) begin
                  state_q <= vtq_pkg::SEQ_ISSUE;
                  step_q  <= vtq_pkg::STP_P_XX;
                  pt_q    <= 1'b0;
                end
              end
              vtq_pkg::REQ_STOP: begin
                drag_q <= 1'b0;
              end
              default: begin
                q_q[0] <= vtq_pkg::qv_t'(vtq_pkg::QUAT_ONE);
                q_q[1] <= '0;
                q_q[2] <= '0;
                q_q[3] <= '0;
              end
            endcase
          end
        end
        vtq_pkg::SEQ_ISSUE: begin
          state_q <= vtq_pkg::SEQ_WAIT;
        end
        vtq_pkg::SEQ_WAIT: begin
          if (alu_rsp_i.done) begin
            step_q <= step_nx;
            if (pt_adv) begin
              pt_q <= 1'b1;
            end
            if (fin) begin
              state_q <= vtq_pkg::SEQ_DONE;
              px_q    <= cx_q;
              py_q    <= cy_q;
            end else begin
              state_q <= vtq_pkg::SEQ_ISSUE;
            end
            if (step_q == vtq_pkg::STP_Q_15) begin
              q_q[0] <= nq_q[0];
              q_q[1] <= nq_q[1];
              q_q[2] <= nq_q[2];
              q_q[3] <= vtq_pkg::to_quat(alu_rsp_i.acc);
            end
          end
        end
        vtq_pkg::SEQ_DONE: begin
          if (out_free_i) begin
            state_q <= vtq_pkg::SEQ_IDLE;
          end
        end
        default: begin
          state_q <= vtq_pkg::SEQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == vtq_pkg::SEQ_IDLE) && cmd_i.valid) begin
      cx_q <= cmd_i.x;
      cy_q <= cmd_i.y;
    end
    if (wb) begin
      case (step_q)
        vtq_pkg::STP_P_YY: begin
          s_q <= alu_rsp_i.acc[31:0];
        end
        vtq_pkg::STP_P_SQ: begin
          if (outside) begin
            len_q <= alu_rsp_i.res;
          end else if (pt_q) begin
            nx_q <= vtq_pkg::crd_t'(cur_x) <<< vtq_pkg::U_SHIFT;
            ny_q <= vtq_pkg::crd_t'(cur_y) <<< vtq_pkg::U_SHIFT;
            nz_q <= res_c;
          end else begin
            fx_q <= vtq_pkg::crd_t'(cur_x) <<< vtq_pkg::U_SHIFT;
            fy_q <= vtq_pkg::crd_t'(cur_y) <<< vtq_pkg::U_SHIFT;
            fz_q <= res_c;
          end
        end
        vtq_pkg::STP_P_DX: begin
          if (pt_q) begin
            nx_q <= cur_x[15] ? -res_c : res_c;
          end else begin
            fx_q <= cur_x[15] ? -res_c : res_c;
          end
        end
        vtq_pkg::STP_P_DY: begin
          if (pt_q) begin
            ny_q <= cur_y[15] ? -res_c : res_c;
            nz_q <= '0;
          end else begin
            fy_q <= cur_y[15] ? -res_c : res_c;
            fz_q <= '0;
          end
        end
        vtq_pkg::STP_C_1:  ax_q   <= vtq_pkg::crd_t'(alu_rsp_i.acc >>> vtq_pkg::UFRAC);
        vtq_pkg::STP_C_3:  ay_q   <= vtq_pkg::crd_t'(alu_rsp_i.acc >>> vtq_pkg::UFRAC);
        vtq_pkg::STP_C_5:  az_q   <= vtq_pkg::crd_t'(alu_rsp_i.acc >>> vtq_pkg::UFRAC);
        vtq_pkg::STP_D_2:  dot_q  <= vtq_pkg::clamp_dot(alu_rsp_i.acc);
        vtq_pkg::STP_L_SQ: len_q  <= alu_rsp_i.res;
        vtq_pkg::STP_H_S:  sn_q   <= alu_rsp_i.res;
        vtq_pkg::STP_H_C:  d_q[0] <= res_c;
        vtq_pkg::STP_V_D0: d_q[1] <= quo_s;
        vtq_pkg::STP_V_D1: d_q[2] <= quo_s;
        vtq_pkg::STP_V_D2: d_q[3] <= quo_s;
        default: begin
          if ((step_q >= vtq_pkg::STP_Q_0) && (qj[1:0] == 2'd3)) begin
            nq_q[qj[3:2]] <= vtq_pkg::to_quat(alu_rsp_i.acc);
          end
        end
      endcase
    end
  end

  assign sts_o.idle = (state_q == vtq_pkg::SEQ_IDLE);
  assign sts_o.done = (state_q == vtq_pkg::SEQ_DONE) && out_free_i;
  assign sts_o.drag = drag_q;
  assign sts_o.qw   = q_q[0];
  assign sts_o.qx   = q_q[1];
  assign sts_o.qy   = q_q[2];
  assign sts_o.qz   = q_q[3];

endmodule
